FILE: rtl/tscc_pkg.sv
package tscc_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned MaxEdgesDef    = 8192;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTREADY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] source_vertex;
    logic [9:0] target_vertex;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] value;
  } out_t;

  // saturate a count into the 11-bit result value
  function automatic logic [10:0] sat11(input logic [31:0] x);
    logic [10:0] r;
    r = (x > 32'd2047) ? 11'h7FF : x[10:0];
    return r;
  endfunction

endpackage

FILE: rtl/tarjan_scc_labeler.sv
// Add edge: S_ADD0, S_ADD1, S_DONE; read: S_RD0, S_RD1, S_DONE; failed checks: S_DONE.
// Clear graph: a sweep over all MAX_VERTICES list heads.
// Run: a depth-first walk from each unvisited root over the n active vertices and E stored
//   edges, through the edge, vertex and stack memories; an edge to a vertex outside the
//   count is skipped.
// One request is in work at a time; a finished result waits in the output register.
// Reset: asynchronous, active low; a sweep then clears all MAX_VERTICES list heads.
module tarjan_scc_labeler #(
  parameter int unsigned MAX_VERTICES = tscc_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = tscc_pkg::MaxEdgesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tscc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tscc_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [10:0]    cfg_data_i
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = VW + 1;
  localparam int CW = EW + 1;

  typedef struct packed {
    logic          valid;
    logic [EW-1:0] head;
    logic [EW-1:0] tail;
  } head_t;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [EW-1:0] cur;
    logic          more;
    logic [NW-1:0] dt;
    logic [NW-1:0] low;
    logic [EW-1:0] tail;
  } frame_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ADD0, S_ADD1, S_CLR, S_RD0, S_RD1, S_RCLR, S_ROOT, S_ROOTW,
    S_VIS0, S_VIS1, S_WALK, S_E1, S_E2, S_POP, S_C0, S_C1, S_P0, S_P1, S_DONE
  } state_e;

  // memories
  logic [VW-1:0] etgt_mem [MAX_EDGES];
  logic [EW-1:0] enext_mem [MAX_EDGES];
  head_t         head_mem [MAX_VERTICES];
  logic [NW-1:0] dt_mem [MAX_VERTICES];
  logic          on_mem [MAX_VERTICES];
  logic [9:0]    lab_mem [MAX_VERTICES];
  frame_t        walk_mem [MAX_VERTICES];
  logic [VW-1:0] cstk_mem [MAX_VERTICES];

  logic          etgt_we;
  logic [EW-1:0] etgt_wa, etgt_ra;
  logic [VW-1:0] etgt_wd, etgt_rd_q;
  logic          enext_we;
  logic [EW-1:0] enext_wa, enext_ra, enext_wd, enext_rd_q;
  logic          head_we;
  logic [VW-1:0] head_wa, head_ra;
  head_t         head_wd, head_rd_q;
  logic          dt_we;
  logic [VW-1:0] dt_wa, dt_ra;
  logic [NW-1:0] dt_wd, dt_rd_q;
  logic          on_we, on_wd, on_rd_q;
  logic [VW-1:0] on_wa, on_ra;
  logic          lab_we;
  logic [VW-1:0] lab_wa, lab_ra;
  logic [9:0]    lab_wd, lab_rd_q;
  logic          walk_we;
  logic [VW-1:0] walk_wa, walk_ra;
  frame_t        walk_wd, walk_rd_q;
  logic          cstk_we;
  logic [VW-1:0] cstk_wa, cstk_ra, cstk_wd, cstk_rd_q;

  always_ff @(posedge clk_i) begin
    if (etgt_we) etgt_mem[etgt_wa] <= etgt_wd;
    etgt_rd_q <= etgt_mem[etgt_ra];
    if (enext_we) enext_mem[enext_wa] <= enext_wd;
    enext_rd_q <= enext_mem[enext_ra];
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
    if (dt_we) dt_mem[dt_wa] <= dt_wd;
    dt_rd_q <= dt_mem[dt_ra];
    if (on_we) on_mem[on_wa] <= on_wd;
    on_rd_q <= on_mem[on_ra];
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    lab_rd_q <= lab_mem[lab_ra];
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    walk_rd_q <= walk_mem[walk_ra];
    if (cstk_we) cstk_mem[cstk_wa] <= cstk_wd;
    cstk_rd_q <= cstk_mem[cstk_ra];
  end

  state_e         state_q;
  tscc_pkg::in_t  req_q;
  tscc_pkg::out_t res_q, out_q;
  logic           out_valid_q;
  logic [10:0]    cfg_q;
  logic [CW-1:0]  cnt_q;
  logic           ready_q;
  logic [NW-1:0]  sw_q, r_q, time_q, ctot_q, wd_q, cd_q;
  logic [VW-1:0]  x_q;
  frame_t         top_q;

  logic [NW-1:0] n;
  logic [VW-1:0] src_idx, tgt_idx;
  logic [EW-1:0] new_e;
  logic          in_src_ok, in_tgt_ok;

  always_comb begin
    if (cfg_q == 11'd0) n = NW'(1);
    else if (32'(cfg_q) > MAX_VERTICES) n = NW'(MAX_VERTICES);
    else n = NW'(cfg_q);
  end

  assign src_idx   = VW'(req_q.source_vertex);
  assign tgt_idx   = VW'(req_q.target_vertex);
  assign new_e     = cnt_q[EW-1:0];
  assign in_src_ok = 32'(in_data_i.source_vertex) < 32'(n);
  assign in_tgt_ok = 32'(in_data_i.target_vertex) < 32'(n);

  always_comb begin
    etgt_we  = 1'b0; etgt_wa  = new_e; etgt_wd = tgt_idx; etgt_ra = top_q.cur;
    enext_we = 1'b0; enext_wa = new_e; enext_wd = '0;     enext_ra = top_q.cur;
    head_we  = 1'b0; head_wa  = src_idx; head_wd = '0;    head_ra = src_idx;
    dt_we    = 1'b0; dt_wa    = sw_q[VW-1:0]; dt_wd = '0; dt_ra = r_q[VW-1:0];
    on_we    = 1'b0; on_wa    = sw_q[VW-1:0]; on_wd = 1'b0; on_ra = etgt_rd_q;
    lab_we   = 1'b0; lab_wa   = cstk_rd_q; lab_wd = 10'(ctot_q); lab_ra = src_idx;
    walk_we  = 1'b0; walk_wa  = wd_q[VW-1:0] - VW'(1); walk_wd = top_q;
    walk_ra  = wd_q[VW-1:0] - VW'(2);
    cstk_we  = 1'b0; cstk_wa  = cd_q[VW-1:0]; cstk_wd = x_q;
    cstk_ra  = cd_q[VW-1:0] - VW'(1);
    case (state_q)
      S_INIT, S_CLR: begin
        head_we = 1'b1;
        head_wa = sw_q[VW-1:0];
      end
      S_ADD0: begin
        etgt_we  = 1'b1;
        enext_we = 1'b1;
      end
      S_ADD1: begin
        head_we = 1'b1;
        if (head_rd_q.valid) begin
          enext_we = 1'b1;
          enext_wa = head_rd_q.tail;
          enext_wd = new_e;
          head_wd  = '{valid: 1'b1, head: head_rd_q.head, tail: new_e};
        end else begin
          head_wd  = '{valid: 1'b1, head: new_e, tail: new_e};
        end
      end
      S_RCLR: begin
        dt_we = 1'b1;
        on_we = 1'b1;
      end
      S_E1: dt_ra = etgt_rd_q;
      S_VIS0: head_ra = x_q;
      S_VIS1: begin
        dt_we   = 1'b1;
        dt_wa   = x_q;
        dt_wd   = time_q + NW'(1);
        on_we   = 1'b1;
        on_wa   = x_q;
        on_wd   = 1'b1;
        cstk_we = 1'b1;
        walk_we = wd_q != '0;
      end
      S_C1: begin
        on_we  = 1'b1;
        on_wa  = cstk_rd_q;
        lab_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      cfg_q       <= 11'd1024;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      sw_q        <= '0;
      r_q         <= '0;
      time_q      <= '0;
      ctot_q      <= '0;
      wd_q        <= '0;
      cd_q        <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q   <= cfg_data_i;
        ready_q <= 1'b0;
      end
      case (state_q)
        S_INIT, S_CLR: begin
          sw_q <= sw_q + NW'(1);
          if (sw_q == NW'(MAX_VERTICES - 1)) begin
            if (state_q == S_INIT) begin
              state_q <= S_IDLE;
            end else begin
              res_q   <= '{status: tscc_pkg::ST_OK, value: 11'd0};
              state_q <= S_DONE;
            end
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            sw_q  <= '0;
            case (in_data_i.opcode)
              tscc_pkg::OP_ADD: begin
                if (!in_src_ok || !in_tgt_ok) begin
                  res_q   <= '{status: tscc_pkg::ST_RANGE, value: tscc_pkg::sat11(32'(cnt_q))};
                  state_q <= S_DONE;
                end else if (32'(cnt_q) >= MAX_EDGES) begin
                  res_q   <= '{status: tscc_pkg::ST_FULL, value: tscc_pkg::sat11(32'(cnt_q))};
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_ADD0;
                end
              end
              tscc_pkg::OP_CLEAR: begin
                cnt_q   <= '0;
                ready_q <= 1'b0;
                state_q <= S_CLR;
              end
              tscc_pkg::OP_RUN: begin
                r_q     <= '0;
                time_q  <= '0;
                ctot_q  <= '0;
                wd_q    <= '0;
                cd_q    <= '0;
                state_q <= S_RCLR;
              end
              default: begin
                if (!in_src_ok) begin
                  res_q   <= '{status: tscc_pkg::ST_RANGE, value: 11'd0};
                  state_q <= S_DONE;
                end else if (!ready_q) begin
                  res_q   <= '{status: tscc_pkg::ST_NOTREADY, value: 11'd0};
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_RD0;
                end
              end
            endcase
          end
        end
        S_ADD0: state_q <= S_ADD1;
        S_ADD1: begin
          cnt_q   <= cnt_q + CW'(1);
          ready_q <= 1'b0;
          res_q   <= '{status: tscc_pkg::ST_OK,
                       value: tscc_pkg::sat11(32'(cnt_q) + 32'd1)};
          state_q <= S_DONE;
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          res_q   <= '{status: tscc_pkg::ST_OK, value: {1'b0, lab_rd_q}};
          state_q <= S_DONE;
        end
        S_RCLR: begin
          sw_q <= sw_q + NW'(1);
          if (sw_q == n - NW'(1)) state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (r_q == n) begin
            ready_q <= 1'b1;
            res_q   <= '{status: tscc_pkg::ST_OK, value: 11'(32'(ctot_q))};
            state_q <= S_DONE;
          end else begin
            state_q <= S_ROOTW;
          end
        end
        S_ROOTW: begin
          if (dt_rd_q == '0) begin
            x_q     <= r_q[VW-1:0];
            state_q <= S_VIS0;
          end else begin
            r_q     <= r_q + NW'(1);
            state_q <= S_ROOT;
          end
        end
        S_VIS0: state_q <= S_VIS1;
        S_VIS1: begin
          // old top, if any, was pushed to the walk memory; the new vertex becomes top
          time_q  <= time_q + NW'(1);
          cd_q    <= cd_q + NW'(1);
          wd_q    <= wd_q + NW'(1);
          top_q   <= '{v: x_q, cur: head_rd_q.head, more: head_rd_q.valid,
                       dt: time_q + NW'(1), low: time_q + NW'(1), tail: head_rd_q.tail};
          state_q <= S_WALK;
        end
        S_WALK: state_q <= top_q.more ? S_E1 : S_POP;
        S_E1: begin
          if (top_q.cur == top_q.tail) top_q.more <= 1'b0;
          else top_q.cur <= enext_rd_q;
          x_q <= etgt_rd_q;
          if ({1'b0, etgt_rd_q} >= n) state_q <= S_WALK;
          else state_q <= S_E2;
        end
        S_E2: begin
          if (dt_rd_q == '0) begin
            state_q <= S_VIS0;
          end else begin
            if (on_rd_q && dt_rd_q < top_q.low) top_q.low <= dt_rd_q;
            state_q <= S_WALK;
          end
        end
        S_POP: state_q <= (top_q.low == top_q.dt) ? S_C0 : S_P0;
        S_C0: begin
          cd_q    <= cd_q - NW'(1);
          state_q <= S_C1;
        end
        S_C1: begin
          if (cstk_rd_q != top_q.v && cd_q != '0) begin
            state_q <= S_C0;
          end else begin
            ctot_q  <= ctot_q + NW'(1);
            state_q <= S_P0;
          end
        end
        S_P0: begin
          if (wd_q > NW'(1)) begin
            state_q <= S_P1;
          end else begin
            wd_q    <= '0;
            r_q     <= r_q + NW'(1);
            state_q <= S_ROOT;
          end
        end
        S_P1: begin
          // parent takes the smaller of its own low link and that of the finished child
          top_q   <= '{v: walk_rd_q.v, cur: walk_rd_q.cur, more: walk_rd_q.more,
                       dt: walk_rd_q.dt,
                       low: (top_q.low < walk_rd_q.low) ? top_q.low : walk_rd_q.low,
                       tail: walk_rd_q.tail};
          wd_q    <= wd_q - NW'(1);
          state_q <= S_WALK;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // stall requests while busy; hold config writes off while busy or while a request is offered
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_walk_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wd_q <= cd_q + NW'(1))
    else $error("walk stack deeper than component stack");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_C0 |-> cd_q != '0)
    else $error("component pop from empty stack");
  a_edge_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_E1 |-> $past(state_q) == S_WALK)
    else $error("edge step without walk decision");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> in_stall_o && !cfg_ready_o)
    else $error("request or config taken while a result is pending");

endmodule
